// ===== sv/fupp_pkg.sv =====
// Shared types and codes for the form-urlencoded pair parser.
// No dependencies; imported by every module of the block.
package fupp_pkg;

  // Result event codes
  localparam logic [2:0] EV_KEY       = 3'd0;
  localparam logic [2:0] EV_VAL       = 3'd1;
  localparam logic [2:0] EV_END       = 3'd2;
  localparam logic [2:0] EV_END_EMPTY = 3'd3;
  localparam logic [2:0] EV_DROP      = 3'd4;
  localparam logic [2:0] EV_SYNTAX    = 3'd5;
  localparam logic [2:0] EV_ESCAPE    = 3'd6;
  localparam logic [2:0] EV_DONE      = 3'd7;

  // Configuration register indexes
  localparam logic CFG_FIELD_SEP = 1'b0;
  localparam logic CFG_UNESCAPE  = 1'b1;

  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QLVL_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // All results caused by one input byte, oldest in slot 0
  typedef struct packed {
    logic [1:0]              count;
    result_t [MAX_RES-1:0]   res;
  } entry_t;

  typedef struct packed {
    logic   wr;
    entry_t entry;
  } q_write_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

// ===== sv/form_urlencoded_pair_parser.sv =====
// Top level of the form-urlencoded pair parser: front end, entry queue and
// back end. Depends on fupp_pkg, fupp_front, fupp_queue and fupp_back.
//
// Takes one byte of a key=value string per cycle while full is low on the
// push/full side; returns tagged key bytes, value bytes, pair ends, drops,
// errors and a done marker on the empty/pop side. A byte is classified and
// decoded in the cycle it is accepted; its results, if any (up to three),
// go into a four-entry queue as one entry and then the output register,
// which hands them out one per cycle while the consumer pops. Sustained
// input is one byte per cycle as long as the consumer pops every cycle and
// bytes average at most one result; a byte with two or three results (end
// of string) holds the output port until all are popped, and full rises
// once the queue has four entries waiting. Configuration writes take
// effect on the next cycle and belong between strings.
module form_urlencoded_pair_parser import fupp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  item_t      in_item,
  output logic       empty,
  input  logic       pop,
  output result_t    out_item,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  q_write_t q_wr;
  q_head_t  head;
  logic     deq;
  logic     accept;

  assign accept = push && !full;

  fupp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr)
  );

  fupp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .deq  (deq),
    .head (head),
    .full (full)
  );

  fupp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .deq      (deq),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

// ===== sv/fupp_front.sv =====
// Front end: accepts bytes, runs the pair/escape state machines, and builds
// one queue entry of results per byte. Holds the configuration registers.
// Depends on fupp_pkg.
module fupp_front import fupp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  item_t    in_item,
  input  logic     cfg_write,
  input  logic     cfg_index,
  input  logic [7:0] cfg_data,
  output q_write_t q_wr
);

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam int         HEX_ALPHA  = 10;

  typedef enum logic [4:0] {
    PS_NEXTKEY = 5'b00001,
    PS_INKEY   = 5'b00010,
    PS_NEXTVAL = 5'b00100,
    PS_INVAL   = 5'b01000,
    PS_ERROR   = 5'b10000
  } parse_state_t;

  typedef enum logic [2:0] {
    ES_NONE  = 3'b001,
    ES_PCT   = 3'b010,
    ES_DIGIT = 3'b100
  } escape_state_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_legal(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           (b == CHAR_DASH) || (b == CHAR_DOT) || (b == CHAR_UNDER) || (b == CHAR_TILDE) ||
           (b == CHAR_PLUS) || (b == CHAR_PCT) || (b == CHAR_STAR);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // {ok, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (is_digit(b)) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end
    if ((b >= 8'h61) && (b <= 8'h66)) begin
      d = b - 8'h61 + 8'(HEX_ALPHA);
      return {1'b1, d[3:0]};
    end
    if ((b >= 8'h41) && (b <= 8'h46)) begin
      d = b - 8'h41 + 8'(HEX_ALPHA);
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  logic [7:0]    field_separator;
  logic          unescape_enable;
  parse_state_t  ps, ps_next;
  escape_state_t es, es_next;
  logic [3:0]    high_nibble, high_nibble_next;

  logic       content_do;
  logic [2:0] content_code;
  logic       byte_emit;
  result_t    byte_res;
  logic [4:0] hex;
  logic [1:0] cnt;
  result_t [MAX_RES-1:0] res_list;
  logic [7:0] b;
  logic       eos;

  assign b   = in_item.in_byte;
  assign eos = in_item.end_of_string;
  assign hex = hex_value(b);

  always_comb begin
    ps_next          = ps;
    es_next          = es;
    high_nibble_next = high_nibble;
    content_do       = 1'b0;
    content_code     = EV_KEY;
    byte_emit        = 1'b0;
    byte_res         = '0;
    cnt              = 2'd0;
    res_list         = '0;

    unique case (ps)
      PS_NEXTKEY: begin
        if (is_legal(b)) begin
          ps_next    = PS_INKEY;
          content_do = 1'b1;
        end else if (!is_space(b)) begin
          ps_next            = PS_ERROR;
          byte_emit          = 1'b1;
          byte_res.event_res = EV_SYNTAX;
        end
      end
      PS_INKEY: begin
        if (b == CHAR_EQ) begin
          es_next          = ES_NONE;
          high_nibble_next = 4'd0;
          ps_next          = PS_NEXTVAL;
        end else if (is_legal(b)) begin
          content_do = 1'b1;
        end else begin
          ps_next            = PS_ERROR;
          byte_emit          = 1'b1;
          byte_res.event_res = EV_SYNTAX;
        end
      end
      PS_NEXTVAL: begin
        if (is_legal(b)) begin
          ps_next      = PS_INVAL;
          content_do   = 1'b1;
          content_code = EV_VAL;
        end else if (b == field_separator) begin
          es_next            = ES_NONE;
          high_nibble_next   = 4'd0;
          ps_next            = PS_NEXTKEY;
          byte_emit          = 1'b1;
          byte_res.event_res = EV_END_EMPTY;
        end else if (!is_space(b)) begin
          ps_next            = PS_ERROR;
          byte_emit          = 1'b1;
          byte_res.event_res = EV_SYNTAX;
        end
      end
      PS_INVAL: begin
        if (b == field_separator) begin
          es_next            = ES_NONE;
          high_nibble_next   = 4'd0;
          ps_next            = PS_NEXTKEY;
          byte_emit          = 1'b1;
          byte_res.event_res = EV_END;
        end else if (is_legal(b)) begin
          content_do   = 1'b1;
          content_code = EV_VAL;
        end else begin
          ps_next            = PS_ERROR;
          byte_emit          = 1'b1;
          byte_res.event_res = EV_SYNTAX;
        end
      end
      PS_ERROR: begin
        ps_next = PS_ERROR;
      end
      default: begin
        ps_next = PS_ERROR;
      end
    endcase

    // Key or value content byte, with optional percent/plus decoding
    if (content_do) begin
      if (!unescape_enable) begin
        es_next          = ES_NONE;
        high_nibble_next = 4'd0;
        byte_emit        = 1'b1;
        byte_res         = '{event_res: content_code, out_byte: b, last: 1'b0};
      end else if (es == ES_NONE) begin
        if (b == CHAR_PCT) begin
          es_next = ES_PCT;
        end else begin
          byte_emit = 1'b1;
          byte_res  = '{event_res: content_code,
                        out_byte: (b == CHAR_PLUS) ? CHAR_SPACE : b, last: 1'b0};
        end
      end else if (!hex[4]) begin
        es_next            = ES_NONE;
        high_nibble_next   = 4'd0;
        ps_next            = PS_ERROR;
        byte_emit          = 1'b1;
        byte_res.event_res = EV_ESCAPE;
      end else if (es == ES_PCT) begin
        high_nibble_next = hex[3:0];
        es_next          = ES_DIGIT;
      end else begin
        byte_emit        = 1'b1;
        byte_res         = '{event_res: content_code, out_byte: {high_nibble, hex[3:0]},
                             last: 1'b0};
        es_next          = ES_NONE;
        high_nibble_next = 4'd0;
      end
    end

    if (byte_emit) begin
      res_list[0] = byte_res;
      cnt         = 2'd1;
    end

    // End of string closes whatever field is open, then marks the string done
    if (eos) begin
      if (ps_next == PS_INKEY) begin
        res_list[cnt] = '{event_res: EV_DROP, out_byte: 8'h00, last: 1'b0};
        cnt           = cnt + 2'd1;
      end else if (ps_next == PS_NEXTVAL) begin
        res_list[cnt] = '{event_res: EV_END_EMPTY, out_byte: 8'h00, last: 1'b0};
        cnt           = cnt + 2'd1;
      end else if (ps_next == PS_INVAL) begin
        res_list[cnt] = '{event_res: EV_END, out_byte: 8'h00, last: 1'b0};
        cnt           = cnt + 2'd1;
      end
      res_list[cnt]    = '{event_res: EV_DONE, out_byte: 8'h00, last: 1'b1};
      cnt              = cnt + 2'd1;
      ps_next          = PS_NEXTKEY;
      es_next          = ES_NONE;
      high_nibble_next = 4'd0;
    end
  end

  assign q_wr.wr          = accept && (cnt != 2'd0);
  assign q_wr.entry.count = cnt;
  assign q_wr.entry.res   = res_list;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps          <= PS_NEXTKEY;
      es          <= ES_NONE;
      high_nibble <= 4'd0;
    end else if (accept) begin
      ps          <= ps_next;
      es          <= es_next;
      high_nibble <= high_nibble_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_separator <= 8'd38;
      unescape_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIELD_SEP: field_separator <= cfg_data;
        CFG_UNESCAPE:  unescape_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A string end always produces an entry whose final result is the done marker
  a_eos_done: assert property (@(posedge clk) disable iff (rst)
    (accept && eos) |-> (q_wr.wr && res_list[cnt - 2'd1].last &&
                         (res_list[cnt - 2'd1].event_res == EV_DONE)))
    else $error("string end without done result");

endmodule

// ===== sv/fupp_queue.sv =====
// Short entry queue between front and back ends; one entry per input byte
// that produced results. Depends on fupp_pkg.
module fupp_queue import fupp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  q_write_t q_wr,
  input  logic     deq,
  output q_head_t  head,
  output logic     full
);

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QLVL_W-1:0]  level;
  logic               wr;

  assign wr   = q_wr.wr && !full;
  assign full = (level == QLVL_W'(QDEPTH));

  assign head.valid = (level != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(wr) - QLVL_W'(deq);
    end
  end

  a_level_ptrs: assert property (@(posedge clk) disable iff (rst)
    level[QPTR_W-1:0] == (wr_ptr - rd_ptr))
    else $error("queue level out of step with pointers");

endmodule

// ===== sv/fupp_back.sv =====
// Back end: walks the results of the head queue entry one at a time into
// the output register. Depends on fupp_pkg.
module fupp_back import fupp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_head_t head,
  output logic    deq,
  input  logic    pop,
  output logic    empty,
  output result_t out_item
);

  logic       out_valid;
  logic [1:0] sub;
  logic       load;
  logic       at_end;

  assign load   = head.valid && (!out_valid || pop);
  assign at_end = (sub == (head.entry.count - 2'd1));
  assign deq    = load && at_end;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= head.entry.res[sub];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= at_end ? 2'd0 : sub + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (sub < head.entry.count))
    else $error("result index past end of entry");

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last) |-> (out_item.event_res == EV_DONE))
    else $error("last flag on a result other than string done");

  a_done_ends_entry: assert property (@(posedge clk) disable iff (rst)
    (load && head.entry.res[sub].last) |-> deq)
    else $error("done result not at end of its entry");

endmodule
